/* rtl/integer_to_english_word_tokens_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the number-to-words block
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ENGLISH_WORD_TOKENS_TOP_MACROS_SVH
`define INTEGER_TO_ENGLISH_WORD_TOKENS_TOP_MACROS_SVH

// Same-cycle implication.
`define ITEW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITEW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/itew_pkg.sv */
// ----------------------------------------------------------------------------
// itew_pkg
// Widths, token codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package itew_pkg;

  localparam int NUM_W      = 31;
  localparam int NUM_BYTES  = (NUM_W + 7) / 8;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int DIGITS     = 10;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int WORD_W     = 5;
  localparam int WORD_BYTES = (WORD_W + 7) / 8;

  // Token codes
  localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
  localparam logic [WORD_W-1:0] TOK_TEEN     = 5'd10;
  localparam logic [WORD_W-1:0] TOK_TENS     = 5'd20;
  localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;

  // Three-digit groups, most significant first in the walk
  localparam logic [1:0] GRP_UNITS     = 2'd0;
  localparam logic [1:0] GRP_THOUSANDS = 2'd1;
  localparam logic [1:0] GRP_MILLIONS  = 2'd2;
  localparam logic [1:0] GRP_BILLIONS  = 2'd3;

  // Word slots inside one group
  localparam logic [2:0] PH_HDIGIT = 3'd0;
  localparam logic [2:0] PH_HWORD  = 3'd1;
  localparam logic [2:0] PH_TENS   = 3'd2;
  localparam logic [2:0] PH_UNIT   = 3'd3;
  localparam logic [2:0] PH_SCALE  = 3'd4;

  typedef struct packed {
    logic load;       // capture number, clear digits, restart walk
    logic conv_step;  // one shift-and-adjust step
    logic pos_inc;    // advance to the next word slot
    logic out_load;   // capture current word into output register
  } cmd_t;

  typedef struct packed {
    logic conv_done;  // final conversion step in progress
    logic pos_end;    // walk stands on the final slot
    logic tok_hit;    // current slot yields a word
    logic out_last;   // held output word is the final one
  } sts_t;

endpackage

/* rtl/itew_ctrl.sv */
// ----------------------------------------------------------------------------
// itew_ctrl
// Sequencer: accept, convert to decimal, walk word slots, hand words out.
// ----------------------------------------------------------------------------
`include "integer_to_english_word_tokens_top_macros.svh"

module itew_ctrl
  import itew_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_WALK,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_CONV;
            in_ready_q <= 1'b0;
          end
        end
        S_CONV: begin
          if (sts_i.conv_done) begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (sts_i.tok_hit) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end else if (sts_i.pos_end) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (sts_i.out_last) begin
              state_q    <= S_IDLE;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= S_WALK;
            end
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.conv_step = (state_q == S_CONV);
    cmd_o.out_load  = (state_q == S_WALK) && sts_i.tok_hit;
    cmd_o.pos_inc   = ((state_q == S_WALK) && !sts_i.tok_hit && !sts_i.pos_end) ||
                      ((state_q == S_OUT) && out_ready_i && !sts_i.out_last);
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `ITEW_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_q, !in_ready_q,
                    "input taken while a word is pending")
  `ITEW_ASSERT_NEXT(a_accept_converts, clk_i, rst_ni, in_valid_i && in_ready_q,
                    cmd_o.conv_step, "accepted number not converted")
  `ITEW_ASSERT_NEXT(a_last_frees, clk_i, rst_ni,
                    out_valid_q && out_ready_i && sts_i.out_last,
                    in_ready_q && !out_valid_q, "final word did not release input")

endmodule

/* rtl/itew_dp.sv */
// ----------------------------------------------------------------------------
// itew_dp
// Binary-to-decimal shifter, word-slot walker and output word register.
// ----------------------------------------------------------------------------
module itew_dp
  import itew_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NUM_W-1:0]  number_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [WORD_W-1:0] word_o,
  output logic              last_o
);

  logic [NUM_W-1:0]  bin_q;
  logic [BCD_W-1:0]  bcd_q, bcd_adj;
  logic [CNT_W-1:0]  cnt_q;
  logic [1:0]        grp_q;
  logic [2:0]        ph_q;
  logic [WORD_W-1:0] word_q, tok;
  logic              last_q, hit, tok_last;

  logic [3:0] dig_h, dig_t, dig_u;
  logic       lower_zero, all_zero, grp_nz, low_grp, t_big;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
      cnt_q <= '0;
      grp_q <= GRP_BILLIONS;
      ph_q  <= PH_HDIGIT;
    end else begin
      if (cmd_i.load) begin
        bcd_q <= '0;
        cnt_q <= '0;
        grp_q <= GRP_BILLIONS;
        ph_q  <= PH_HDIGIT;
      end else if (cmd_i.conv_step) begin
        bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUM_W-1]};
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.pos_inc) begin
        if (ph_q == PH_SCALE) begin
          ph_q  <= PH_HDIGIT;
          grp_q <= grp_q - 1'b1;
        end else begin
          ph_q <= ph_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= number_i;
    end else if (cmd_i.conv_step) begin
      bin_q <= {bin_q[NUM_W-2:0], 1'b0};
    end
    if (cmd_i.out_load) begin
      word_q <= tok;
      last_q <= tok_last;
    end
  end

  // Pick the digits of the current group and check the groups below it
  always_comb begin
    case (grp_q)
      GRP_UNITS: begin
        {dig_h, dig_t, dig_u} = bcd_q[11:0];
        lower_zero = 1'b1;
      end
      GRP_THOUSANDS: begin
        {dig_h, dig_t, dig_u} = bcd_q[23:12];
        lower_zero = (bcd_q[11:0] == '0);
      end
      GRP_MILLIONS: begin
        {dig_h, dig_t, dig_u} = bcd_q[35:24];
        lower_zero = (bcd_q[23:0] == '0);
      end
      default: begin
        {dig_h, dig_t, dig_u} = {8'd0, bcd_q[39:36]};
        lower_zero = (bcd_q[35:0] == '0);
      end
    endcase
  end

  assign all_zero = (bcd_q == '0);
  assign grp_nz   = (dig_h != 4'd0) || (dig_t != 4'd0) || (dig_u != 4'd0);
  assign low_grp  = (grp_q == GRP_UNITS);
  assign t_big    = (dig_t >= 4'd2);

  // Word, presence and final mark of the current slot
  always_comb begin
    hit      = 1'b0;
    tok      = TOK_ZERO;
    tok_last = 1'b0;
    case (ph_q)
      PH_HDIGIT: begin
        hit = (dig_h != 4'd0);
        tok = {1'b0, dig_h};
      end
      PH_HWORD: begin
        hit      = (dig_h != 4'd0);
        tok      = TOK_HUNDRED;
        tok_last = low_grp && (dig_t == 4'd0) && (dig_u == 4'd0);
      end
      PH_TENS: begin
        hit      = (dig_t != 4'd0) || (dig_u != 4'd0) || (low_grp && all_zero);
        tok_last = low_grp && !(t_big && (dig_u != 4'd0));
        if (t_big) begin
          tok = TOK_TENS + {1'b0, dig_t} - 5'd2;
        end else if (dig_t == 4'd1) begin
          tok = TOK_TEEN + {1'b0, dig_u};
        end else begin
          tok = {1'b0, dig_u};
        end
      end
      PH_UNIT: begin
        hit      = t_big && (dig_u != 4'd0);
        tok      = {1'b0, dig_u};
        tok_last = low_grp;
      end
      PH_SCALE: begin
        hit      = !low_grp && grp_nz;
        tok      = TOK_HUNDRED + {3'd0, grp_q};
        tok_last = lower_zero;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign sts_o.conv_done = cmd_i.conv_step && (cnt_q == CNT_W'(NUM_W - 1));
  assign sts_o.pos_end   = low_grp && (ph_q == PH_SCALE);
  assign sts_o.tok_hit   = hit;
  assign sts_o.out_last  = last_q;

  assign word_o = word_q;
  assign last_o = last_q;

endmodule

/* rtl/integer_to_english_word_tokens_top.sv */
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_top
// Names a 31-bit unsigned number in English as a stream of word tokens.
// ----------------------------------------------------------------------------
// Send one number on the slave stream; the block answers with 1 to 16 word
// tokens on the master stream, the final one flagged by tlast. Zero gives the
// single word zero. One number is in flight at a time: the slave side stays
// not-ready from acceptance until the final word is taken. Per number: an
// accept, then shift-and-add-three binary-to-decimal conversion of the 31
// input bits (one input bit per cycle), then a walk of the word slots from the
// billions group down, stopping on the final word (at most 19 slots, five per
// group), with a handoff of each emitted word that waits until the consumer
// takes it.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_top
  import itew_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Slave stream: one number per word
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [8*NUM_BYTES-1:0]  s_axis_tdata_i,   // [30:0] number, [31] ignored
  // Master stream: one token per word
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [8*WORD_BYTES-1:0] m_axis_tdata_o,   // [4:0] word, [7:5] zero fill
  output logic                    m_axis_tlast_o
);

  cmd_t              cmd;
  sts_t              sts;
  logic [WORD_W-1:0] word;
  logic              last;

  // Sequence the conversion and the word walk
  itew_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold the number, its decimal digits and the outgoing word
  itew_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (s_axis_tdata_i[NUM_W-1:0]),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .word_o   (word),
    .last_o   (last)
  );

  // Pad the token up to a whole byte
  assign m_axis_tdata_o = {{(8*WORD_BYTES-WORD_W){1'b0}}, word};
  assign m_axis_tlast_o = last;

endmodule

/* tb/integer_to_english_word_tokens_checker.sv */
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_checker
// Watches both streams, names each accepted number and checks every token.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_checker
  import itew_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [8*NUM_BYTES-1:0]  s_tdata_i,   // [30:0] number, [31] ignored
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  input  logic [8*WORD_BYTES-1:0] m_tdata_i,   // [4:0] word, [7:5] zero fill
  input  logic                    m_tlast_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam logic [WORD_W-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [WORD_W-1:0] WORD_MILLION  = 5'd30;
  localparam logic [WORD_W-1:0] WORD_BILLION  = 5'd31;
  localparam int                MAX_WORDS     = 16;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } token_t;

  token_t            expected_tokens[$];
  logic [WORD_W-1:0] spoken[MAX_WORDS];
  int                spoken_len;
  int                fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_tokens.size();

  // Drop anything past the sixteenth word, the most the block ever gives.
  function automatic void say(input logic [WORD_W-1:0] w);
    if (spoken_len < MAX_WORDS) begin
      spoken[spoken_len] = w;
      spoken_len++;
    end
  endfunction

  // Name one nonzero group below a thousand.
  function automatic void say_group(input int unsigned grp);
    int unsigned rest;
    rest = grp % 100;
    if (grp >= 100) begin
      say(WORD_W'(grp / 100));
      say(TOK_HUNDRED);
    end
    if (rest >= 20) begin
      say(WORD_W'(TOK_TENS + rest / 10 - 2));
      if (rest % 10 != 0) say(WORD_W'(rest % 10));
    end else if (rest > 0) begin
      say(WORD_W'(rest));
    end
  endfunction

  task automatic name_number(input logic [8*NUM_BYTES-1:0] raw);
    logic [NUM_W-1:0] num;
    int unsigned      bil, mil, tho, low;
    token_t           tok;
    num        = raw[NUM_W-1:0];   // the top bit is ignored
    bil        = num / 1000000000;
    mil        = (num / 1000000) % 1000;
    tho        = (num / 1000) % 1000;
    low        = num % 1000;
    spoken_len = 0;
    if (num == 0) begin
      say(TOK_ZERO);
    end else begin
      if (bil != 0) begin
        say_group(bil);
        say(WORD_BILLION);
      end
      if (mil != 0) begin
        say_group(mil);
        say(WORD_MILLION);
      end
      if (tho != 0) begin
        say_group(tho);
        say(WORD_THOUSAND);
      end
      if (low != 0) say_group(low);
    end
    for (int k = 0; k < spoken_len; k++) begin
      tok.word = spoken[k];
      tok.last = (k == spoken_len - 1);
      expected_tokens.push_back(tok);
    end
  endtask

  always @(posedge clk_i) begin
    token_t exp_tok;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) name_number(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected word, expected none, got word %0d last %0d",
                   $time, m_tdata_i[WORD_W-1:0], m_tlast_i);
          fail_count++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (m_tdata_i[WORD_W-1:0] !== exp_tok.word) begin
            $display("%0t: word mismatch, expected %0d, got %0d",
                     $time, exp_tok.word, m_tdata_i[WORD_W-1:0]);
            fail_count++;
          end
          if (m_tlast_i !== exp_tok.last) begin
            $display("%0t: last mismatch, expected %0d, got %0d",
                     $time, exp_tok.last, m_tlast_i);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_integer_to_english_word_tokens_top.sv */
// ----------------------------------------------------------------------------
// tb_integer_to_english_word_tokens_top
// Drives numbers into the word-token block under bursty input and a
// stalling consumer; a side checker predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_integer_to_english_word_tokens_top
  import itew_pkg::*;
();

  localparam int RANDOM_NUMBERS = 450;
  localparam int IDLE_LIMIT     = 3000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 100;   // a bit over one full number of latency
  localparam int CORNER_COUNT   = 25;

  typedef enum logic [1:0] {
    RX_STEADY,   // take every word
    RX_COIN,     // take about half the words
    RX_SPARSE,   // take one word in eight
    RX_BLOCKED   // hold ready low for the whole stretch
  } rx_mode_e;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [8*NUM_BYTES-1:0]  s_axis_tdata  = '0;   // [30:0] number, [31] ignored
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [8*WORD_BYTES-1:0] m_axis_tdata;          // [4:0] word, [7:5] zero fill
  logic                    m_axis_tlast;

  int       fail_count;
  int       tokens_pending;
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       rx_left = 0;
  rx_mode_e rx_mode = RX_STEADY;

  // Edges of the range, every word kind, skipped groups, the sixteen-word cap
  // and the ignored top bit.
  logic [31:0] corner_numbers[CORNER_COUNT] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd20, 32'd21, 32'd99,
    32'd100, 32'd101, 32'd110, 32'd999, 32'd1000, 32'd1001, 32'd20020,
    32'd1000000, 32'd1000000000, 32'd1000000001, 32'd2000000000,
    32'd2147483647, 32'd1777777777, 32'd1111111111, 32'h8000_0000, 32'hFFFF_FFFF
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  integer_to_english_word_tokens_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  integer_to_english_word_tokens_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (tokens_pending)
  );

  // Consumer: switch between stall patterns after a random stretch so that
  // stalls land on the first word, the middle of a run and the last word.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 30) : $urandom_range(5, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STEADY: begin
        m_axis_tready <= 1'b1;
      end
      RX_COIN: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        m_axis_tready <= 1'b0;
      end
    endcase
  end

  // Watchdog: end the run if neither stream moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_integer_to_english_word_tokens_top: FAIL");
      $finish;
    end
  end

  // Pick one group value: often zero, small or dense with words.
  function automatic int unsigned pick_group();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 19);
      2:       return $urandom_range(0, 999);
      default: return $urandom_range(1, 9) * 100 + $urandom_range(2, 9) * 10
                      + $urandom_range(1, 9);
    endcase
  endfunction

  function automatic logic [31:0] pick_number();
    longint value;
    case ($urandom_range(0, 9))
      0, 1: begin
        value = $urandom();   // full 32 bits, top bit included
      end
      2: begin
        value = $urandom_range(0, 99);
      end
      3: begin
        value = $urandom_range(0, 999);
      end
      default: begin
        value = longint'($urandom_range(0, 2)) * 1000000000
              + longint'(pick_group()) * 1000000
              + longint'(pick_group()) * 1000
              + longint'(pick_group());
        if (value > 64'd2147483647) value -= 1000000000;
      end
    endcase
    return value[31:0];
  endfunction

  // Present one number and hold it until the block takes it. Between bursts,
  // drop valid for a random gap; inside a burst keep valid high.
  task automatic send_number(input logic [31:0] value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < CORNER_COUNT; i++) send_number(corner_numbers[i]);
    for (int i = 0; i < RANDOM_NUMBERS; i++) send_number(pick_number());
    s_axis_tvalid <= 1'b0;

    // Drain: let the checker take in the final number, wait for the last
    // expected token, then a latency's worth more to catch any stray word.
    @(posedge clk_i);
    while (tokens_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_integer_to_english_word_tokens_top: PASS");
    end else begin
      $display("tb_integer_to_english_word_tokens_top: FAIL");
    end
    $finish;
  end

endmodule
